@@ rtl/core/mrc_pkg.sv @@
package mrc_pkg;

	localparam int PAGE_W   = 16;
	localparam int DIM_W    = 14;
	localparam int AREA_W   = 2 * DIM_W;
	localparam int SCALED_W = AREA_W + 7;
	localparam int RANK_W   = 6;
	localparam int DROP_W   = 7;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 16;

	// similarity test: SIM_DEN * |old - new| < SIM_NUM * new
	localparam int SIM_NUM = 35;
	localparam int SIM_DEN = 100;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [AREA_W-1:0] area;
	} tag_t;

	typedef struct packed {
		logic valid;
		tag_t tag;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_EVAL,
		CELL_HIT,
		CELL_COMPACT,
		CELL_PUSH,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [PAGE_W-1:0]   page;
		logic [DIM_W-1:0]    mw;
		logic [DIM_W-1:0]    mh;
		logic [AREA_W-1:0]   area;
		logic [SCALED_W-1:0] area35;
		entry_t              ins;
	} cell_ctl_t;

	// first field in the highest bits
	typedef struct packed {
		logic [DROP_W-1:0] dropped;
		logic              stored;
		logic [RANK_W-1:0] rank;
		logic              hit;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_EVAL,
		ST_DECIDE,
		ST_COMPACT,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/core/mrc_cell.sv @@
module mrc_cell
	import mrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left_ent,
	input  entry_t    right_ent,
	input  logic      right_drop,
	input  logic      seen_in,
	input  logic      hole_in,
	output entry_t    ent,
	output logic      drop,
	output logic      match,
	output logic      seen_out,
	output logic      hole_out
);

	logic                valid_q;
	logic                match_q;
	logic                drop_q;
	tag_t                tag_q;
	logic                page_eq;
	logic [AREA_W-1:0]   diff;
	logic [SCALED_W-1:0] scaled;
	logic                take_left;
	logic                take_right;

	always_comb begin
		page_eq    = valid_q && (tag_q.page == ctl.page);
		diff       = (tag_q.area > ctl.area) ? (tag_q.area - ctl.area) : (ctl.area - tag_q.area);
		scaled     = SCALED_W'(diff) * SCALED_W'(SIM_DEN);
		seen_out   = seen_in | match_q;
		hole_out   = hole_in | drop_q;
		take_left  = (ctl.op == CELL_PUSH) || ((ctl.op == CELL_HIT) && !seen_in);
		take_right = (ctl.op == CELL_COMPACT) && hole_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_EVAL: begin
					match_q <= page_eq && (tag_q.width == ctl.mw) && (tag_q.height == ctl.mh);
					drop_q  <= page_eq && (ctl.area != '0) && (scaled < ctl.area35);
				end
				CELL_HIT, CELL_PUSH: begin
					if (take_left) valid_q <= left_ent.valid;
				end
				CELL_COMPACT: begin
					if (take_right) begin
						valid_q <= right_ent.valid;
						drop_q  <= right_drop;
					end
				end
				CELL_CLEAR: begin
					valid_q <= 1'b0;
					match_q <= 1'b0;
					drop_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) tag_q <= left_ent.tag;
		else if (take_right) tag_q <= right_ent.tag;
	end

	assign ent   = '{valid: valid_q, tag: tag_q};
	assign drop  = drop_q;
	assign match = match_q;

endmodule

@@ rtl/core/mru_render_cache_policy_unit.sv @@
// channel | dir | width | contents (lsb first)
// s_*     | in  | 48    | page_number, req_width, req_height, quarter_turns, render_ok
// m_*     | out | 16    | hit, hit_rank, stored, dropped_count
// cfg_*   | in  | 1     | cache_enable
// A hit, a failed render or a request with caching off passes through ST_MUL, ST_SCALE,
// ST_EVAL, ST_DECIDE and ST_FINISH before the next accept. A stored miss adds ST_COMPACT,
// which removes each entry dropped as similar, one at a time through the cell chain, and
// then pushes the new entry. The area multiply and its scaling are registered in ST_MUL and ST_SCALE.
// A new request is taken while a result waits on m_tready;
// a stalled output holds the next request at its last step. Reset empties the list
// and enables caching.
module mru_render_cache_policy_unit
	import mrc_pkg::*;
#(
	parameter int CACHE_DEPTH = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // page_number, req_width, req_height, quarter_turns, render_ok
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // hit, hit_rank, stored, dropped_count, pad
	input  logic             cfg_we,
	input  logic             cfg_wdata
);

	state_t              state_q, state_d;
	logic                enable_q;
	logic [PAGE_W-1:0]   page_q;
	logic [DIM_W-1:0]    w_q, h_q;
	logic                odd_q, ok_q;
	logic [AREA_W-1:0]   area_q;
	logic [SCALED_W-1:0] area35_q;
	logic [DROP_W-1:0]   cnt_q;
	result_t             pend_q, pend_d;
	result_t             out_q;
	logic                out_valid_q;
	logic                pend_ld, cnt_inc, out_ld, accept;
	cell_ctl_t           ctl;
	logic [DIM_W-1:0]    mw, mh;
	logic                any_match, any_drop, found;
	logic [RANK_W-1:0]   rank;

	entry_t ent   [CACHE_DEPTH];
	logic   drop  [CACHE_DEPTH];
	logic   match [CACHE_DEPTH];
	logic   seen  [CACHE_DEPTH+1];
	logic   hole  [CACHE_DEPTH+1];

	assign seen[0] = 1'b0;
	assign hole[0] = 1'b0;

	for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
		entry_t left_e, right_e;
		logic   right_d;
		if (k == 0) begin : g_first
			assign left_e = ctl.ins;
		end else begin : g_mid
			assign left_e = ent[k-1];
		end
		if (k == CACHE_DEPTH - 1) begin : g_last
			assign right_e = '0;
			assign right_d = 1'b0;
		end else begin : g_inner
			assign right_e = ent[k+1];
			assign right_d = drop[k+1];
		end
		mrc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_ent   (left_e),
			.right_ent  (right_e),
			.right_drop (right_d),
			.seen_in    (seen[k]),
			.hole_in    (hole[k]),
			.ent        (ent[k]),
			.drop       (drop[k]),
			.match      (match[k]),
			.seen_out   (seen[k+1]),
			.hole_out   (hole[k+1])
		);
	end

	always_comb begin
		any_match = 1'b0;
		any_drop  = 1'b0;
		found     = 1'b0;
		rank      = '0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			any_match = any_match | match[i];
			any_drop  = any_drop | drop[i];
			if (match[i] && !found) begin
				rank  = RANK_W'(i);
				found = 1'b1;
			end
		end
	end

	assign mw = odd_q ? h_q : w_q;
	assign mh = odd_q ? w_q : h_q;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		pend_d  = '0;
		pend_ld = 1'b0;
		cnt_inc = 1'b0;
		out_ld  = 1'b0;
		ctl.op  = CELL_HOLD;
		ctl.page   = page_q;
		ctl.mw     = mw;
		ctl.mh     = mh;
		ctl.area   = area_q;
		ctl.area35 = area35_q;
		ctl.ins.valid = 1'b1;
		ctl.ins.tag   = '{page: page_q, width: w_q, height: h_q, area: area_q};
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EVAL;
			ST_EVAL: begin
				ctl.op  = CELL_EVAL;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				pend_ld = 1'b1;
				state_d = ST_FINISH;
				if (enable_q && any_match) begin
					ctl.op      = CELL_HIT;
					ctl.ins.tag = '{page: page_q, width: mw, height: mh, area: area_q};
					pend_d.hit  = 1'b1;
					pend_d.rank = rank;
				end else if (enable_q && ok_q) begin
					pend_ld = 1'b0;
					state_d = ST_COMPACT;
				end
			end
			ST_COMPACT: begin
				if (any_drop) begin
					ctl.op  = CELL_COMPACT;
					cnt_inc = 1'b1;
				end else begin
					ctl.op         = CELL_PUSH;
					pend_ld        = 1'b1;
					pend_d.stored  = 1'b1;
					pend_d.dropped = cnt_q + DROP_W'(ent[CACHE_DEPTH-1].valid);
					state_d        = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we && !cfg_wdata) ctl.op = CELL_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enable_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) enable_q <= cfg_wdata;
			if (out_ld) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= s_tdata[15:0];
			w_q    <= s_tdata[29:16];
			h_q    <= s_tdata[43:30];
			odd_q  <= s_tdata[44];
			ok_q   <= s_tdata[46];
			cnt_q  <= '0;
		end else if (cnt_inc) begin
			cnt_q <= cnt_q + DROP_W'(1);
		end
		if (state_q == ST_MUL) area_q <= AREA_W'(w_q) * AREA_W'(h_q);
		if (state_q == ST_SCALE) area35_q <= SCALED_W'(area_q) * SCALED_W'(SIM_NUM);
		if (pend_ld) pend_q <= pend_d;
		if (out_ld) out_q <= pend_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

@@ rtl/core/mrc_checker.sv @@
module mrc_checker
	import mrc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[7] && (m_tdata[14:8] == '0))
		else $error("hit with store or drop");

	a_miss_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[6:1] == '0))
		else $error("miss with nonzero rank");

	a_drop_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[14:8] != '0) |-> m_tdata[7])
		else $error("drop without store");

endmodule

bind mru_render_cache_policy_unit mrc_checker u_mrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
